// File: rtl/pfla_pkg.sv
// ----------------------------------------------------------------------------
// Page free list allocator package
// Shared widths, status codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package pfla_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int PAGE_W    = 10;
  localparam int COUNT_W   = $clog2(MAX_PAGES + 1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_HEADER = 2'd1,
    STATUS_RANGE  = 2'd2,
    STATUS_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_BUMP = 2'd1,
    SEL_HEAD = 2'd2
  } out_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     ram_rd;
    logic     pop;
    logic     push;
    logic     bump;
    logic     load_out;
    out_sel_e out_sel;
    status_e  out_status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_valid;
    logic req_cmd;
    logic head_nz;
    logic count_full;
    logic pid_header;
    logic pid_range;
    logic out_busy;
  } dp_sts_t;

endpackage

// File: rtl/pfla_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying an allocate or free command.
// ----------------------------------------------------------------------------
interface pfla_req_if;
  import pfla_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [PAGE_W-1:0] page_id;

  modport source (output valid, output cmd, output page_id, input ready);
  modport sink   (input valid, input cmd, input page_id, output ready);
endinterface

// File: rtl/pfla_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying the allocated page and a status code.
// ----------------------------------------------------------------------------
interface pfla_rsp_if;
  import pfla_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] got_page;
  logic [1:0]        status;

  modport source (output valid, output got_page, output status, input ready);
  modport sink   (input valid, input got_page, input status, output ready);
endinterface

// File: rtl/pfla_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pfla_dp.sv
// ----------------------------------------------------------------------------
// Page free list allocator datapath
// Free list head, high-water count, link memory and response register.
// ----------------------------------------------------------------------------
module pfla_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic                      req_cmd_i,
  input  logic [pfla_pkg::PAGE_W-1:0] req_page_id_i,
  input  logic                      rsp_ready_i,
  output logic                      rsp_valid_o,
  output logic [pfla_pkg::PAGE_W-1:0] rsp_got_page_o,
  output logic [1:0]                rsp_status_o,
  input  pfla_pkg::ctrl_cmd_t       cmd_i,
  output pfla_pkg::dp_sts_t         sts_o
);
  import pfla_pkg::*;

  logic [PAGE_W-1:0]  head_q, head_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               out_valid_q, out_valid_d;
  logic [PAGE_W-1:0]  out_page_q, out_page_d;
  status_e            out_status_q;
  logic [PAGE_W-1:0]  link_rdata;

  pfla_ram #(
    .WIDTH(PAGE_W),
    .DEPTH(MAX_PAGES)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(req_page_id_i),
    .wdata_i(head_q),
    .re_i   (cmd_i.ram_rd),
    .raddr_i(head_q),
    .rdata_o(link_rdata)
  );

  always_comb begin
    head_d = head_q;
    if (cmd_i.pop) begin
      head_d = link_rdata;
    end else if (cmd_i.push) begin
      head_d = req_page_id_i;
    end
  end

  assign count_d = cmd_i.bump ? count_q + COUNT_W'(1) : count_q;

  always_comb begin
    case (cmd_i.out_sel)
      SEL_BUMP: out_page_d = count_q[PAGE_W-1:0];
      SEL_HEAD: out_page_d = head_q;
      default:  out_page_d = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= COUNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_page_q   <= out_page_d;
      out_status_q <= cmd_i.out_status;
    end
  end

  assign rsp_valid_o    = out_valid_q;
  assign rsp_got_page_o = out_page_q;
  assign rsp_status_o   = out_status_q;

  always_comb begin
    sts_o.req_valid  = req_valid_i;
    sts_o.req_cmd    = req_cmd_i;
    sts_o.head_nz    = (head_q != '0);
    sts_o.count_full = (count_q >= COUNT_W'(MAX_PAGES));
    sts_o.pid_header = (req_page_id_i == '0);
    sts_o.pid_range  = ({{(COUNT_W-PAGE_W){1'b0}}, req_page_id_i} >= count_q);
    sts_o.out_busy   = out_valid_q && !rsp_ready_i;
  end

endmodule

// File: rtl/pfla_ctrl.sv
// ----------------------------------------------------------------------------
// Page free list allocator controller
// Decodes each request and sequences the link memory read for a pop.
// ----------------------------------------------------------------------------
module pfla_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfla_pkg::dp_sts_t   sts_i,
  output logic                req_ready_o,
  output pfla_pkg::ctrl_cmd_t cmd_o
);
  import pfla_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic state_q, state_d;
  logic accept;

  // A new request may enter once the response register is free or draining.
  assign req_ready_o = (state_q == ST_IDLE) && !sts_i.out_busy;
  assign accept      = req_ready_o && sts_i.req_valid;

  always_comb begin
    state_d          = state_q;
    cmd_o.ram_rd     = 1'b0;
    cmd_o.pop        = 1'b0;
    cmd_o.push       = 1'b0;
    cmd_o.bump       = 1'b0;
    cmd_o.load_out   = 1'b0;
    cmd_o.out_sel    = SEL_ZERO;
    cmd_o.out_status = STATUS_OK;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (sts_i.req_cmd == CMD_ALLOC) begin
            if (sts_i.head_nz) begin
              cmd_o.ram_rd = 1'b1;
              state_d      = ST_POP;
            end else if (!sts_i.count_full) begin
              cmd_o.bump     = 1'b1;
              cmd_o.load_out = 1'b1;
              cmd_o.out_sel  = SEL_BUMP;
            end else begin
              cmd_o.load_out   = 1'b1;
              cmd_o.out_status = STATUS_FULL;
            end
          end else begin
            cmd_o.load_out = 1'b1;
            if (sts_i.pid_header) begin
              cmd_o.out_status = STATUS_HEADER;
            end else if (sts_i.pid_range) begin
              cmd_o.out_status = STATUS_RANGE;
            end else begin
              cmd_o.push = 1'b1;
            end
          end
        end
      end
      ST_POP: begin
        // The link of the old head is now on the read port.
        cmd_o.pop      = 1'b1;
        cmd_o.load_out = 1'b1;
        cmd_o.out_sel  = SEL_HEAD;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_pop_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ram_rd |=> (state_q == ST_POP) && cmd_o.pop)
    else $error("pop did not follow a link read");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !sts_i.out_busy)
    else $error("response register loaded while still held");

  a_rd_wr_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.ram_rd && cmd_o.push))
    else $error("link read and write in one cycle");

  a_push_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> sts_i.req_cmd == CMD_FREE && !sts_i.pid_header && !sts_i.pid_range)
    else $error("push of an invalid page");
`endif

endmodule

// File: rtl/page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Page free list allocator
// LIFO free list of pages with a high-water count; page 0 is reserved.
//
//   Channel  Dir  Payload                         Handshake
//   req_i    in   cmd[0], page_id[9:0]            valid/ready
//   rsp_o    out  got_page[9:0], status[1:0]      valid/ready
//
// A free, a fresh-page allocate or an error loads the response on accept;
// a popping allocate first reads the link RAM, then returns the old head.
// One request is in flight at a time; the response register lets the next
// request enter in the cycle its response is taken.
// Reset empties the free list and sets the count to one; link RAM contents
// are not cleared, as only links written by a free are ever read.
// A stalled response holds req_i.ready low until it is taken.
// ----------------------------------------------------------------------------
module page_free_list_allocator (
  input logic       clk_i,
  input logic       rst_ni,
  pfla_req_if.sink   req_i,
  pfla_rsp_if.source rsp_o
);
  import pfla_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  pfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (dp_sts),
    .req_ready_o(req_i.ready),
    .cmd_o      (ctrl_cmd)
  );

  pfla_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_cmd_i     (req_i.cmd),
    .req_page_id_i (req_i.page_id),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_got_page_o(rsp_o.got_page),
    .rsp_status_o  (rsp_o.status),
    .cmd_i         (ctrl_cmd),
    .sts_o         (dp_sts)
  );

endmodule
